@@ rtl/rmsn_pkg.sv @@
package rmsn_pkg;

  // sizing
  localparam int unsigned ROW_MAX_DEF = 64;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned SQ_W        = 2 * DATA_W - 1;
  localparam int unsigned SUM_W_DEF   = SQ_W + $clog2(ROW_MAX_DEF);
  localparam int unsigned ROOT_W_DEF  = (SUM_W_DEF + 2) / 2;

  // fixed-point formats
  localparam int unsigned INV_W    = 32;
  localparam int unsigned QUO_W    = INV_W + 1;
  localparam int unsigned SCALE_SH = 16;
  localparam int unsigned RND_SH   = 36;
  localparam int unsigned RMS_MAX  = 2 ** DATA_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_SCALE = 1'b0,
    CFG_EPSILON    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] gain;
    logic                     pad;
    logic                     row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] normalized;
    logic        [DATA_W-1:0] rms_value;
    logic                     final_res;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic scale;
    logic root_go;
    logic recip_go;
    logic read;
    logic prod;
    logic mult;
    logic round;
    logic advance;
  } rmsn_cmd_t;

  typedef struct packed {
    logic root_done;
    logic recip_done;
    logic last_elem;
  } rmsn_sts_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCALE,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_RECIP_GO,
    ST_RECIP_WAIT,
    ST_READ,
    ST_PROD,
    ST_MULT,
    ST_ROUND,
    ST_EMIT
  } rmsn_state_e;

endpackage

@@ rtl/rmsn_root.sv @@
module rmsn_root import rmsn_pkg::*; #(
  parameter int unsigned ROOT_W = ROOT_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  done_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [ROOT_W:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [ROOT_W+2:0] rem_sh, trial, diff;
  logic              fits;

  // one root bit per cycle, restoring
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

@@ rtl/rmsn_div.sv @@
module rmsn_div import rmsn_pkg::*; #(
  parameter int unsigned DIV_W = ROOT_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic [QUO_W-1:0]  quo_o,
  output logic              done_o
);

  // computes 2^INV_W / divisor, one quotient bit per cycle
  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] dsor_q, rem_q;
  logic [QUO_W-1:0] quo_q;

  logic [DIV_W:0] rem_sh, diff;
  logic           fits;

  // dividend is a single one in its top bit
  assign rem_sh = {rem_q, (cnt_q == '0)};
  assign fits   = rem_sh >= {1'b0, dsor_q};
  assign diff   = rem_sh - {1'b0, dsor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsor_q <= divisor_i;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

@@ rtl/rmsn_dp.sv @@
module rmsn_dp import rmsn_pkg::*; #(
  parameter int unsigned ROW_MAX = ROW_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  in_item_t              in_data_i,
  input  rmsn_cmd_t             cmd_i,
  output rmsn_sts_t             sts_o,
  output out_item_t             out_data_o
);

  localparam int unsigned IDX_W  = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int unsigned FILL_W = $clog2(ROW_MAX + 1);
  localparam int unsigned SUM_W  = SQ_W + $clog2(ROW_MAX);
  localparam int unsigned PROD_W = SUM_W + CFG_W;
  localparam int unsigned ROOT_W = (SUM_W + 2) / 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned MAG_W  = 2 * DATA_W - 1;
  localparam int unsigned WIDE_W = MAG_W + INV_W;
  localparam int unsigned Q_W    = WIDE_W - RND_SH;
  localparam logic [WIDE_W-1:0] RND_HALF = WIDE_W'(1) << (RND_SH - 1);
  localparam logic [DATA_W-1:0] SAT_POS  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG  = {1'b1, {(DATA_W-1){1'b0}}};

  // control state
  logic [CFG_W-1:0]  mean_scale_q, epsilon_q;
  logic [FILL_W-1:0] fill_q, k_q, k_next;
  logic [SUM_W-1:0]  sum_q;

  // payload
  logic [2*DATA_W-1:0] mem_q [ROW_MAX];
  logic [2*DATA_W-1:0] rd_q;
  logic [SUM_W-1:0]    scaled_q;
  logic                neg_q;
  logic [MAG_W-1:0]    mag_q;
  logic [WIDE_W-1:0]   wide_q;
  out_item_t           out_q;

  logic                       has_room;
  logic signed [2*DATA_W-1:0] sq, prod, prod_abs;
  logic [PROD_W-1:0]          scale_prod;
  logic [RAD_W-1:0]           radicand;
  logic [ROOT_W-1:0]          root;
  logic                       root_done, recip_done;
  logic [QUO_W-1:0]           quo;
  logic [INV_W-1:0]           inv;
  logic [WIDE_W-1:0]          rnd;
  logic [Q_W-1:0]             qv, qv_neg;
  logic [DATA_W-1:0]          norm, rms_sat;

  assign has_room = fill_q != FILL_W'(ROW_MAX);
  assign k_next   = k_q + FILL_W'(1);
  assign sq       = in_data_i.sample * in_data_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_scale_q <= CFG_W'(RMS_MAX);
      epsilon_q    <= CFG_W'(1);
      fill_q       <= '0;
      k_q          <= '0;
      sum_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MEAN_SCALE: mean_scale_q <= cfg_wdata_i;
          CFG_EPSILON:    epsilon_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.take && has_room) begin
        fill_q <= fill_q + FILL_W'(1);
        if (!in_data_i.pad) begin
          sum_q <= sum_q + SUM_W'(sq[SQ_W-1:0]);
        end
      end
      if (cmd_i.advance) begin
        if (sts_o.last_elem) begin
          fill_q <= '0;
          k_q    <= '0;
          sum_q  <= '0;
        end else begin
          k_q <= k_next;
        end
      end
    end
  end

  // element buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && has_room) begin
      mem_q[fill_q[IDX_W-1:0]] <= {in_data_i.sample, in_data_i.gain};
    end
    if (cmd_i.read) begin
      rd_q <= mem_q[k_q[IDX_W-1:0]];
    end
  end

  // mean square and root
  assign scale_prod = PROD_W'(sum_q) * PROD_W'(mean_scale_q);
  assign radicand   = RAD_W'(scaled_q) + RAD_W'(epsilon_q);

  rmsn_root #(.ROOT_W(ROOT_W)) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_go),
    .rad_i   (radicand),
    .root_o  (root),
    .done_o  (root_done)
  );

  rmsn_div #(.DIV_W(ROOT_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.recip_go),
    .divisor_i (root),
    .quo_o     (quo),
    .done_o    (recip_done)
  );

  // zero root and root of one both land here
  assign inv = quo[INV_W] ? {INV_W{1'b1}} : quo[INV_W-1:0];

  assign rms_sat = (root > ROOT_W'(RMS_MAX)) ? DATA_W'(RMS_MAX) : root[DATA_W-1:0];

  // per element scaling
  assign prod     = $signed(rd_q[2*DATA_W-1:DATA_W]) * $signed(rd_q[DATA_W-1:0]);
  assign prod_abs = prod[2*DATA_W-1] ? -prod : prod;
  assign rnd      = wide_q + RND_HALF;
  assign qv       = rnd[WIDE_W-1:RND_SH];
  assign qv_neg   = Q_W'(0) - qv;

  always_comb begin
    if (neg_q) begin
      norm = (qv > Q_W'(2 ** (DATA_W - 1))) ? SAT_NEG : qv_neg[DATA_W-1:0];
    end else begin
      norm = (qv > Q_W'(2 ** (DATA_W - 1) - 1)) ? SAT_POS : qv[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      scaled_q <= scale_prod[SCALE_SH +: SUM_W];
    end
    if (cmd_i.prod) begin
      neg_q <= prod[2*DATA_W-1];
      mag_q <= prod_abs[MAG_W-1:0];
    end
    if (cmd_i.mult) begin
      wide_q <= WIDE_W'(mag_q) * WIDE_W'(inv);
    end
    if (cmd_i.round) begin
      out_q.normalized <= norm;
      out_q.rms_value  <= rms_sat;
      out_q.final_res  <= sts_o.last_elem;
    end
  end

  assign sts_o.root_done  = root_done;
  assign sts_o.recip_done = recip_done;
  assign sts_o.last_elem  = k_next == fill_q;
  assign out_data_o       = out_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(ROW_MAX))
    else $error("fill count beyond row capacity");

  a_emit_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (k_q < fill_q))
    else $error("emitting past the buffered elements");
`endif

endmodule

@@ rtl/rmsn_ctrl.sv @@
module rmsn_ctrl import rmsn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      row_end_i,
  input  logic      out_stall_i,
  input  rmsn_sts_t sts_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output rmsn_cmd_t cmd_o
);

  rmsn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (row_end_i) begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd_o.root_go = 1'b1;
        state_d       = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sts_i.root_done) begin
          state_d = ST_RECIP_GO;
        end
      end
      ST_RECIP_GO: begin
        cmd_o.recip_go = 1'b1;
        state_d        = ST_RECIP_WAIT;
      end
      ST_RECIP_WAIT: begin
        if (sts_i.recip_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last_elem ? ST_LOAD : ST_READ;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_row_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && row_end_i) |=> in_stall_o)
    else $error("input taken right after a row end");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result beat is offered");
`endif

endmodule

@@ rtl/rms_norm_row.sv @@
// channel  | dir | handshake                  | beat
// ---------+-----+----------------------------+----------------------------------
// cfg      | in  | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
// in       | in  | in_valid_i / in_stall_o    | in_data_i  (sample, gain, pad, row_end)
// out      | out | out_valid_o / out_stall_i  | out_data_o (normalized, rms_value, final_res)
//
// input beats are accepted while the row is loading
// after the row end beat the sum of squares is scaled, then its root and the
//   reciprocal of the root are found, one bit per cycle in each unit
// then per result beat: buffer read, two multiplies, rounding, and the offer
// in_stall_o is high after the row end beat until the last result beat is taken
// reset clears the row, the sum of squares and the configuration registers to their defaults

module rms_norm_row import rmsn_pkg::*; #(
  parameter int unsigned ROW_MAX = ROW_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // element beats
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  // command and status between sequencer and datapath
  rmsn_cmd_t cmd;
  rmsn_sts_t sts;

  // sequencer: load, root and reciprocal, then one result beat per buffered element
  rmsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .row_end_i   (in_data_i.row_end),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // datapath: element buffer, sum of squares, sqrt and reciprocal units,
  // scaling multipliers and the output register
  rmsn_dp #(.ROW_MAX(ROW_MAX)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
